/* sv/mrt_pkg.sv */
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants of the mesh route table.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int MAX_NODES_DEF = 32;
  localparam logic [31:0] MS_PER_MIN = 32'd60000;

  localparam logic [1:0] CMD_DATA     = 2'd0;
  localparam logic [1:0] CMD_ANNOUNCE = 2'd1;
  localparam logic [1:0] CMD_SWEEP    = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OWN     = 3'd1;
  localparam logic [2:0] ST_BETTER  = 3'd2;
  localparam logic [2:0] ST_WORSE   = 3'd3;
  localparam logic [2:0] ST_UPDATED = 3'd4;
  localparam logic [2:0] ST_BADADDR = 3'd5;

  localparam logic [1:0] REG_OWN   = 2'd0;
  localparam logic [1:0] REG_TTL   = 2'd1;
  localparam logic [1:0] REG_MIN   = 2'd2;
  localparam logic [1:0] REG_BCAST = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_SWEEP, S_OUT
  } state_t;

  typedef struct packed {
    logic start;      // latch transaction, issue reads
    logic exec;       // evaluate the latched transaction
    logic sweep_rd;   // issue read of sweep entry
    logic sweep_ev;   // evaluate sweep entry
    logic out_valid;
  } ctrl_t;

  typedef struct packed {
    logic is_sweep;
    logic sweep_last;
  } stat_t;

endpackage

/* sv/mesh_route_table_top.sv */
// ----------------------------------------------------------------------------
// mesh_route_table_top
// Distance-vector route table with data, announce, sweep and query commands.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Contents
// in_      input      in_valid/in_stall  command and packet fields
// out_     output     out_valid/out_stall status and route fields
// cfg_     input      cfg_valid/cfg_ready register index and data
//
// Data, announce and query pass through read and evaluate states before the
// result is offered; the next transaction can be accepted once it is taken.
// An age sweep reads one entry per cycle and offers its result once the last
// entry is evaluated. One transaction is in flight; the input stalls until
// its result is taken, so a stalled result holds off the next transaction.
// Reset restores the register defaults and marks only the own entry active.
module mesh_route_table_top import mrt_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_sender,
  input  logic [7:0]  in_last_node,
  input  logic [7:0]  in_destination,
  input  logic [7:0]  in_ttl,
  input  logic [7:0]  in_packet_id,
  input  logic signed [15:0] in_rssi,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_next_hop,
  output logic [7:0]  out_hop_count,
  output logic signed [15:0] out_link_rssi,
  output logic        out_is_active,
  output logic [7:0]  out_removed_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  mrt_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .out_stall, .out_valid,
    .stat, .ctrl);

  mrt_datapath #(.MAX_NODES(MAX_NODES)) u_dp (.clk, .rst_n, .ctrl, .stat,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .in_command, .in_sender, .in_last_node, .in_destination, .in_ttl,
    .in_packet_id, .in_rssi, .in_now_ms, .out_status, .out_next_hop,
    .out_hop_count, .out_link_rssi, .out_is_active, .out_removed_count);
endmodule

/* sv/mrt_ram.sv */
// ----------------------------------------------------------------------------
// mrt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* sv/mrt_datapath.sv */
// ----------------------------------------------------------------------------
// mrt_datapath
// Route table storage, command evaluation and result register.
// ----------------------------------------------------------------------------
module mrt_datapath import mrt_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_t       ctrl,
  output stat_t       stat,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [7:0]  cfg_val,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_sender,
  input  logic [7:0]  in_last_node,
  input  logic [7:0]  in_destination,
  input  logic [7:0]  in_ttl,
  input  logic [7:0]  in_packet_id,
  input  logic signed [15:0] in_rssi,
  input  logic [31:0] in_now_ms,
  output logic [2:0]  out_status,
  output logic [7:0]  out_next_hop,
  output logic [7:0]  out_hop_count,
  output logic signed [15:0] out_link_rssi,
  output logic        out_is_active,
  output logic [7:0]  out_removed_count
);
  localparam int AW = $clog2(MAX_NODES);
  localparam int IW = 56; // heard(32) hops id next

  logic [7:0] own_r, sttl_r, imin_r, bcast_r;
  logic [MAX_NODES-1:0] act_r;
  logic [1:0]  cmd_r;
  logic [7:0]  snd_r, lst_r, dst_r, pid_r, hops_r;
  logic [15:0] rs_r;
  logic [31:0] now_r;
  logic [AW-1:0] scnt_r;
  logic [7:0]  rem_r;
  logic [39:0] limit_r;

  // Two RAM copies give the sender/destination and last-node reads at once.
  logic [IW-1:0] a_raw, b_raw, a_rd, b_rd, wr_d;
  logic [15:0] ra_raw, ra_rd, rw_d;
  logic [AW-1:0] a_addr, b_addr, w_addr;
  logic we_i, we_r;

  // Entries never written since reset read as zero.
  logic [MAX_NODES-1:0] vi_r, vr_r;
  logic va_r, vb_r, vra_r;

  // Merged info write port: the sender write of a data packet comes in the cycle
  // after the last-node write.
  logic [AW-1:0] wa_m;
  logic [IW-1:0] wd_m;
  logic we_m;

  function automatic logic ok(input logic [7:0] a);
    return a >= 8'd1 && {24'd0, a} <= MAX_NODES;
  endfunction

  function automatic logic [AW-1:0] ix(input logic [7:0] a);
    logic [7:0] t;
    t = a - 8'd1;
    return t[AW-1:0];
  endfunction

  logic [7:0] key_a;
  assign key_a = ctrl.start ? ((in_command == CMD_QUERY) ? in_destination : in_sender)
                            : ((cmd_r == CMD_QUERY) ? dst_r : snd_r);
  // While sweeping, the entry after the one being evaluated is fetched.
  assign a_addr = ctrl.sweep_ev ? scnt_r + 1'b1 : (ctrl.sweep_rd ? scnt_r : ix(key_a));
  assign b_addr = ix(ctrl.start ? in_last_node : lst_r);

  mrt_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_ia (.clk, .we(we_m), .waddr(wa_m),
    .wdata(wd_m), .raddr(a_addr), .rdata(a_raw));
  mrt_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_ib (.clk, .we(we_m), .waddr(wa_m),
    .wdata(wd_m), .raddr(b_addr), .rdata(b_raw));
  mrt_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_ra (.clk, .we(we_r), .waddr(w_addr),
    .wdata(rw_d), .raddr(a_addr), .rdata(ra_raw));

  assign a_rd = va_r ? a_raw : '0;
  assign b_rd = vb_r ? b_raw : '0;
  assign ra_rd = vra_r ? ra_raw : '0;

  // Field split of an info word.
  logic [31:0] a_ht;
  logic [7:0]  a_hp, a_id, a_nh;
  logic [7:0]  b_hp, b_id, b_nh;
  assign {a_ht, a_hp, a_id, a_nh} = a_rd;
  assign b_hp = b_rd[23:16];
  assign b_id = b_rd[15:8];
  assign b_nh = b_rd[7:0];

  logic [AW-1:0] si, li, di;
  assign si = ix(snd_r);
  assign li = ix(lst_r);
  assign di = ix(dst_r);

  logic [2:0] st_n;
  logic [7:0] nh_n, hc_n;
  logic [15:0] rsq_n;
  logic ia_n;
  logic [MAX_NODES-1:0] act_nxt;
  logic [31:0] age;

  assign age = now_r - a_ht;
  assign stat.is_sweep = (cmd_r == CMD_SWEEP);
  assign stat.sweep_last = ({{(32-AW){1'b0}}, scnt_r} == MAX_NODES - 1);

  always_comb begin
    we_i = 1'b0; we_r = 1'b0; w_addr = si; wr_d = a_rd; rw_d = rs_r;
    st_n = ST_OK; nh_n = '0; hc_n = '0; rsq_n = '0; ia_n = 1'b0;
    act_nxt = act_r;
    if (ctrl.exec) begin
      case (cmd_r)
        CMD_DATA: begin
          if (!ok(snd_r) || !ok(lst_r)) st_n = ST_BADADDR;
          else if (snd_r == own_r) begin
            st_n = ST_OWN;
            we_i = 1'b1; we_r = 1'b1; w_addr = li; wr_d = {now_r, b_hp, b_id, b_nh};
          end else begin
            we_i = 1'b1; we_r = 1'b1; w_addr = li;
            wr_d = act_r[li] ? {now_r, b_hp, b_id, b_nh} : {now_r, 8'd0, 8'd0, lst_r};
            act_nxt[li] = 1'b1;
          end
        end
        CMD_ANNOUNCE: begin
          if (!ok(snd_r)) st_n = ST_BADADDR;
          else if (pid_r == a_id) begin
            if (hops_r < a_hp || (hops_r == a_hp && $signed(rs_r) > $signed(ra_rd))) begin
              st_n = ST_BETTER; we_i = 1'b1; we_r = 1'b1;
              wr_d = {a_ht, hops_r, a_id, lst_r};
            end else st_n = ST_WORSE;
          end else begin
            st_n = ST_UPDATED; we_i = 1'b1; we_r = 1'b1;
            wr_d = {a_ht, hops_r, pid_r, lst_r};
          end
        end
        CMD_QUERY: begin
          if (dst_r == bcast_r) begin
            nh_n = bcast_r;
            if (ok(dst_r)) begin hc_n = a_hp; rsq_n = ra_rd; ia_n = act_r[di]; end
          end else if (!ok(dst_r)) st_n = ST_BADADDR;
          else begin
            nh_n = act_r[di] ? a_nh : 8'd0; hc_n = a_hp; rsq_n = ra_rd; ia_n = act_r[di];
          end
        end
        default: ;
      endcase
    end
    if (ctrl.sweep_ev) begin
      if (act_r[scnt_r] && ({{(8-AW){1'b0}}, scnt_r} + 8'd1 != own_r) &&
          {8'd0, age} >= limit_r)
        act_nxt[scnt_r] = 1'b0;
    end
  end

  // Sender step of a data packet: done in the cycle after exec (sender entry may
  // be the just-written last-node entry, whose activity is then known).
  logic snd_pend_r;
  logic [MAX_NODES-1:0] act_fin;
  logic we_s;
  always_comb begin
    act_fin = act_nxt;
    we_s = snd_pend_r && hops_r != 8'd0 && !act_r[si];
    if (we_s) act_fin[si] = 1'b1;
    if (cfg_we && cfg_idx == REG_OWN && ok(cfg_val)) act_fin[ix(cfg_val)] = 1'b1;
  end

  logic [IW-1:0] s_word;
  // Sender fields heard_time and rssi are kept; a fresh read is taken in EXEC.
  logic [31:0] s_ht_r;
  assign s_word = {s_ht_r, hops_r, 8'd0, lst_r};

  assign we_m = we_i | we_s;
  assign wa_m = we_s ? si : w_addr;
  assign wd_m = we_s ? s_word : wr_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= 8'd1; sttl_r <= 8'd7; imin_r <= 8'd5; bcast_r <= 8'd255;
      act_r <= {{(MAX_NODES-1){1'b0}}, 1'b1};
      vi_r <= '0; vr_r <= '0;
      snd_pend_r <= 1'b0; out_status <= ST_OK;
    end else begin
      act_r <= act_fin;
      if (we_m) vi_r[wa_m] <= 1'b1;
      if (we_r) vr_r[w_addr] <= 1'b1;
      if (cfg_we) begin
        case (cfg_idx)
          REG_OWN: own_r <= cfg_val;
          REG_TTL: sttl_r <= cfg_val;
          REG_MIN: imin_r <= cfg_val;
          REG_BCAST: bcast_r <= cfg_val;
          default: ;
        endcase
      end
      snd_pend_r <= ctrl.exec && cmd_r == CMD_DATA && st_n == ST_OK;
      if (ctrl.exec || ctrl.sweep_ev) out_status <= st_n;
    end
  end

  always_ff @(posedge clk) begin
    va_r <= vi_r[a_addr];
    vb_r <= vi_r[b_addr];
    vra_r <= vr_r[a_addr];
    if (ctrl.start) begin
      cmd_r <= in_command; snd_r <= in_sender; lst_r <= in_last_node;
      dst_r <= in_destination; pid_r <= in_packet_id; rs_r <= in_rssi;
      now_r <= in_now_ms;
      hops_r <= (in_ttl >= sttl_r) ? 8'd0 : sttl_r - in_ttl;
      limit_r <= 40'(imin_r) * 40'(MS_PER_MIN);
      scnt_r <= '0; rem_r <= '0;
    end
    if (ctrl.exec) s_ht_r <= a_ht;
    if (ctrl.sweep_ev) begin
      if (act_nxt[scnt_r] != act_r[scnt_r]) rem_r <= rem_r + 8'd1;
      scnt_r <= scnt_r + 1'b1;
    end
    if (ctrl.exec || ctrl.sweep_ev) begin
      out_next_hop <= nh_n; out_hop_count <= hc_n; out_link_rssi <= rsq_n;
      out_is_active <= ia_n;
      out_removed_count <= (ctrl.sweep_ev && stat.sweep_last) ?
          rem_r + 8'(act_nxt[scnt_r] != act_r[scnt_r]) : 8'd0;
    end
  end
endmodule

/* sv/mrt_ctrl.sv */
// ----------------------------------------------------------------------------
// mrt_ctrl
// Sequencer for read, evaluate, sweep and result hand-off.
// ----------------------------------------------------------------------------
module mrt_ctrl import mrt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  out_stall,
  output logic  out_valid,
  input  stat_t stat,
  output ctrl_t ctrl
);
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_READ;
      S_READ:  state_nxt = stat.is_sweep ? S_SWEEP : S_EXEC;
      S_EXEC:  state_nxt = S_OUT;
      S_SWEEP: if (stat.sweep_last) state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      S_IDLE:  ctrl.start = in_valid;
      S_READ:  ctrl.sweep_rd = stat.is_sweep;
      S_EXEC:  ctrl.exec = 1'b1;
      S_SWEEP: begin ctrl.sweep_ev = 1'b1; ctrl.sweep_rd = 1'b1; end
      S_OUT:   ctrl.out_valid = 1'b1;
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ctrl.out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

/* sv/mrt_checker.sv */
// ----------------------------------------------------------------------------
// mrt_props
// Port-level checks of the route table handshakes and result codes.
// ----------------------------------------------------------------------------
module mrt_props import mrt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status
);
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("second transaction taken");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_BADADDR) else $error("undefined status code");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_status))
    else $error("stalled result changed");
endmodule

bind mesh_route_table_top mrt_props u_chk (.clk, .rst_n, .in_valid, .in_stall,
  .out_valid, .out_stall, .out_status);
